// ===== rtl/cmdrsp_pkg.sv =====
// shared types, codes and constants of the command responder
// used by cmdrsp_tmr_unit and command_responder_with_timers_unit
`default_nettype none

package cmdrsp_pkg;

   localparam int TIMER_COUNT = 16;
   localparam int VAR_COUNT   = 16;
   localparam int TIDX_W      = $clog2(TIMER_COUNT);
   localparam int VIDX_W      = $clog2(VAR_COUNT);
   localparam int TIMER_W     = 16;
   localparam int WORD_W      = 32;
   localparam int ARG_W       = 16;
   localparam int HEAD_W      = 8;
   localparam int CSR_IDX_W   = 3;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 40;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MOVE        = 3'd0,
      CSR_ROTATE      = 3'd1,
      CSR_MOTOR_VALUE = 3'd2,
      CSR_MOTOR_TIME  = 3'd3,
      CSR_MOTORS_DONE = 3'd4
   } csr_idx_type;

   // order ids from the upper nibble of the head byte
   typedef enum logic [3:0] {
      ORD_STOP        = 4'd0,
      ORD_MOVE        = 4'd1,
      ORD_ROTATE      = 4'd2,
      ORD_HALT        = 4'd3,
      ORD_MOTOR_VALUE = 4'd4,
      ORD_MOTOR_TIME  = 4'd5,
      ORD_PUMP        = 4'd6,
      ORD_MOTOR_SEL   = 4'd7,
      ORD_MOTOR_ARG   = 4'd8,
      ORD_VAR_WRITE   = 4'd9,
      ORD_VAR_READ    = 4'd10,
      ORD_TRACK       = 4'd11
   } order_id_type;

   // message kinds in the upper nibble of the result head
   typedef enum logic [3:0] {
      MSG_ACK  = 4'h0,
      MSG_DONE = 4'h1,
      MSG_VAR  = 4'h2
   } msg_kind_type;

   // timer slots touched by orders
   localparam logic [TIDX_W-1:0] T_MOVE        = 4'd1;
   localparam logic [TIDX_W-1:0] T_ROTATE      = 4'd2;
   localparam logic [TIDX_W-1:0] T_HALT        = 4'd3;
   localparam logic [TIDX_W-1:0] T_MOTOR_VALUE = 4'd4;
   localparam logic [TIDX_W-1:0] T_MOTOR_TIME  = 4'd5;
   localparam logic [TIDX_W-1:0] T_PUMP        = 4'd6;
   localparam logic [TIDX_W-1:0] T_MOTORS_DONE = 4'd7;
   localparam logic [TIDX_W-1:0] T_VAR_WRITE   = 4'd9;
   localparam logic [TIDX_W-1:0] T_VAR_READ    = 4'd10;
   localparam logic [TIDX_W-1:0] T_TRACK       = 4'd11;

   typedef enum logic [2:0] {
      TOP_NONE,
      TOP_LOAD,
      TOP_CLEAR,
      TOP_INC,
      TOP_DEC
   } tmr_op_type;

   typedef struct packed {
      logic                 en;
      tmr_op_type           op;
      logic [TIDX_W-1:0]    idx;
      logic [TIMER_W-1:0]   value;
   } tmr_cmd_type;

   typedef struct packed {
      logic expired;   // selected timer holds one, a decrement ends it
   } tmr_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACK,
      ST_ACT,
      ST_REPLY,
      ST_WALK,
      ST_FLUSH
   } state_type;

   // power-up words of the variable store (single-precision patterns)
   function automatic logic [WORD_W-1:0] var_init(input logic [VIDX_W-1:0] idx);
      logic [WORD_W-1:0] w;
      case (idx)
         4'd0:    w = 32'h3F80_0000;
         4'd1:    w = 32'h4049_0E56;
         4'd2:    w = 32'h402E_147B;
         4'd3:    w = 32'h3FD8_1062;
         4'd4:    w = 32'h3DCC_CCCD;
         4'd5:    w = 32'h0000_0000;
         4'd6:    w = 32'hC170_0000;
         4'd7:    w = 32'h3EE6_6666;
         default: w = '0;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/cmdrsp_tmr_unit.sv =====
// timer bank with one shared load, clear, increment and decrement unit
// depends on cmdrsp_pkg
`default_nettype none

module cmdrsp_tmr_unit
   import cmdrsp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire tmr_cmd_type   tmr_cmd,
   output tmr_stat_type       tmr_stat
);

   logic [TIMER_W-1:0] tmr_ff [TIMER_COUNT];
   logic [TIMER_W-1:0] rd_val;
   logic [TIMER_W-1:0] wr_val;

   assign rd_val           = tmr_ff[tmr_cmd.idx];
   assign tmr_stat.expired = (rd_val == TIMER_W'(1));

   // the one arithmetic unit, shared by every timer order and every tick step
   always_comb begin
      case (tmr_cmd.op)
         TOP_LOAD:  wr_val = tmr_cmd.value;
         TOP_CLEAR: wr_val = '0;
         TOP_INC:   wr_val = (&rd_val) ? rd_val : rd_val + TIMER_W'(1);
         TOP_DEC:   wr_val = (rd_val == '0) ? rd_val : rd_val - TIMER_W'(1);
         default:   wr_val = rd_val;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TIMER_COUNT; i++) begin
            tmr_ff[i] <= '0;
         end
      end else if (tmr_cmd.en) begin
         tmr_ff[tmr_cmd.idx] <= wr_val;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/command_responder_with_timers_unit.sv =====
// command responder top: order sequencer, tick walk, variable store, result register
// depends on cmdrsp_pkg and cmdrsp_tmr_unit
//
//   channel  dir  handshake              payload
//   req_     in   tvalid/tready          tuser: command; tdata: head, arg_high, arg_low
//   rsp_     out  tvalid/tready          tdata: head, payload; tlast: last of run
//   csr_     in   wen (no wait)          index 0..4, 16-bit data
//
// an order runs through accept, ack beat, one action step (three for halt),
//   plus a reply beat for a variable read
// a tick runs through accept, sixteen steps of the shared timer unit, one flush;
//   a tick while stopped ends at accept and returns straight to idle
// the result register holds a beat until taken; a new beat waits while it is full
// reset is synchronous active high and clears timers, flags and the store to power-up values
`default_nettype none

module command_responder_with_timers_unit
   import cmdrsp_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   // request stream
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [REQ_DATA_W-1:0]   req_tdata,   // head_byte, arg_high, arg_low
   input  wire logic                    req_tuser,   // command (1 = tick)
   // response stream
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [RSP_DATA_W-1:0]        rsp_tdata,   // msg_head, msg_payload
   output logic                         rsp_tlast,   // last_of_run
   // configuration writes
   input  wire logic                    csr_wen,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [TIMER_W-1:0]      csr_wdata
);

   // duration registers
   logic [TIMER_W-1:0] move_dur_ff, rotate_dur_ff, mval_dur_ff, mtime_dur_ff, mdone_dur_ff;

   // latched order
   logic [HEAD_W-1:0]  head_ff;
   logic [ARG_W-1:0]   arg_hi_ff, arg_lo_ff;

   // sequencer
   state_type          state_ff, state_in;
   logic [1:0]         step_ff, step_in;
   logic [TIDX_W-1:0]  idx_ff, idx_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [TIDX_W-1:0]  pend_idx_ff, pend_idx_in;

   // small state of the orders
   logic               stop_ff, tracking_ff;
   logic [3:0]         countdown_ff;
   logic [ARG_W-1:0]   motor_mask_ff, pump_mask_ff;
   logic [WORD_W-1:0]  var_ff [VAR_COUNT];

   // result register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_last_ff;

   tmr_cmd_type        tmr_cmd;
   tmr_stat_type       tmr_stat;

   logic               out_free;
   logic               emit;
   logic [HEAD_W-1:0]  emit_head;
   logic [WORD_W-1:0]  emit_payload;
   logic               emit_last;
   logic               act_do;
   logic               walk_go;
   logic               act_last;
   logic               req_fire;
   order_id_type       order_id;
   logic [3:0]         cplm;
   logic               motor_hit;

   assign order_id  = order_id_type'(head_ff[7:4]);
   assign cplm      = head_ff[3:0];
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign req_fire  = req_tvalid && req_tready;
   assign walk_go   = !pend_valid_ff || out_free;
   assign motor_hit = (countdown_ff != 4'd0) && motor_mask_ff[cplm];

   cmdrsp_tmr_unit u_tmr (
      .clock    (clock),
      .reset    (reset),
      .tmr_cmd  (tmr_cmd),
      .tmr_stat (tmr_stat)
   );

   // only the halt order needs more than one action step
   assign act_last = (order_id != ORD_HALT) || (step_ff == 2'd2);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (!req_tuser) begin
                  state_in = ST_ACK;
               end else if (!stop_ff) begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_ACK: begin
            if (out_free) begin
               state_in = ST_ACT;
            end
         end
         ST_ACT: begin
            if (act_last) begin
               state_in = (order_id == ORD_VAR_READ) ? ST_REPLY : ST_IDLE;
            end
         end
         ST_REPLY: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_WALK: begin
            if (walk_go && (idx_ff == TIDX_W'(TIMER_COUNT - 1))) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready    = 1'b0;
      emit          = 1'b0;
      emit_head     = '0;
      emit_payload  = '0;
      emit_last     = 1'b0;
      act_do        = 1'b0;
      step_in       = step_ff;
      idx_in        = idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      tmr_cmd       = '{en: 1'b0, op: TOP_NONE, idx: idx_ff, value: '0};
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            step_in    = '0;
            idx_in     = '0;
         end
         ST_ACK: begin
            emit      = out_free;
            emit_head = {MSG_ACK, head_ff[7:4]};
            emit_last = (order_id != ORD_VAR_READ);
         end
         ST_ACT: begin
            act_do  = (step_ff == 2'd0);
            step_in = act_last ? 2'd0 : step_ff + 2'd1;
            tmr_cmd.en = 1'b1;
            case (order_id)
               ORD_MOVE: begin
                  tmr_cmd.op    = TOP_LOAD;
                  tmr_cmd.idx   = T_MOVE;
                  tmr_cmd.value = move_dur_ff;
               end
               ORD_ROTATE: begin
                  tmr_cmd.op    = TOP_LOAD;
                  tmr_cmd.idx   = T_ROTATE;
                  tmr_cmd.value = rotate_dur_ff;
               end
               ORD_HALT: begin
                  case (step_ff)
                     2'd0: begin
                        tmr_cmd.op  = TOP_CLEAR;
                        tmr_cmd.idx = T_ROTATE;
                     end
                     2'd1: begin
                        tmr_cmd.op  = TOP_CLEAR;
                        tmr_cmd.idx = T_MOVE;
                     end
                     default: begin
                        tmr_cmd.op  = TOP_INC;
                        tmr_cmd.idx = T_HALT;
                     end
                  endcase
               end
               ORD_MOTOR_VALUE: begin
                  tmr_cmd.op    = TOP_LOAD;
                  tmr_cmd.idx   = T_MOTOR_VALUE;
                  tmr_cmd.value = mval_dur_ff;
               end
               ORD_MOTOR_TIME: begin
                  tmr_cmd.op    = TOP_LOAD;
                  tmr_cmd.idx   = T_MOTOR_TIME;
                  tmr_cmd.value = mtime_dur_ff;
               end
               ORD_PUMP: begin
                  tmr_cmd.op  = TOP_INC;
                  tmr_cmd.idx = T_PUMP;
               end
               ORD_MOTOR_ARG: begin
                  // count ends on this argument
                  tmr_cmd.en    = motor_hit && (countdown_ff == 4'd1);
                  tmr_cmd.op    = TOP_LOAD;
                  tmr_cmd.idx   = T_MOTORS_DONE;
                  tmr_cmd.value = mdone_dur_ff;
               end
               ORD_VAR_WRITE: begin
                  tmr_cmd.op  = TOP_INC;
                  tmr_cmd.idx = T_VAR_WRITE;
               end
               ORD_VAR_READ: begin
                  tmr_cmd.op  = TOP_INC;
                  tmr_cmd.idx = T_VAR_READ;
               end
               ORD_TRACK: begin
                  tmr_cmd.op  = TOP_INC;
                  tmr_cmd.idx = T_TRACK;
               end
               default: tmr_cmd.en = 1'b0;
            endcase
         end
         ST_REPLY: begin
            emit         = out_free;
            emit_head    = {MSG_VAR, cplm};
            emit_payload = var_ff[cplm];
            emit_last    = 1'b1;
         end
         ST_WALK: begin
            // one timer a cycle unless stalled; a new expiry pushes the previous one out
            tmr_cmd.en  = walk_go;
            tmr_cmd.op  = TOP_DEC;
            tmr_cmd.idx = idx_ff;
            if (walk_go) begin
               idx_in = idx_ff + TIDX_W'(1);
               if (tmr_stat.expired) begin
                  emit          = pend_valid_ff;
                  emit_head     = {MSG_DONE, pend_idx_ff};
                  pend_valid_in = 1'b1;
                  pend_idx_in   = idx_ff;
               end
            end
         end
         ST_FLUSH: begin
            // the held expiry is the final beat of this tick
            emit          = pend_valid_ff && out_free;
            emit_head     = {MSG_DONE, pend_idx_ff};
            emit_last     = 1'b1;
            if (out_free) begin
               pend_valid_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= '0;
         idx_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         idx_ff        <= idx_in;
         pend_valid_ff <= pend_valid_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_idx_ff <= pend_idx_in;
      if (req_fire) begin
         head_ff   <= req_tdata[7:0];
         arg_hi_ff <= req_tdata[23:8];
         arg_lo_ff <= req_tdata[39:24];
      end
      if (emit) begin
         rsp_data_ff <= {emit_payload, emit_head};
         rsp_last_ff <= emit_last;
      end
   end

   // duration registers, writes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         move_dur_ff   <= TIMER_W'(160);
         rotate_dur_ff <= TIMER_W'(110);
         mval_dur_ff   <= TIMER_W'(150);
         mtime_dur_ff  <= TIMER_W'(100);
         mdone_dur_ff  <= TIMER_W'(190);
      end else if (csr_wen) begin
         case (csr_idx_type'(csr_index))
            CSR_MOVE:        move_dur_ff   <= csr_wdata;
            CSR_ROTATE:      rotate_dur_ff <= csr_wdata;
            CSR_MOTOR_VALUE: mval_dur_ff   <= csr_wdata;
            CSR_MOTOR_TIME:  mtime_dur_ff  <= csr_wdata;
            CSR_MOTORS_DONE: mdone_dur_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // flags, masks, motor count and variable store, updated on the first action step
   always_ff @(posedge clock) begin
      if (reset) begin
         stop_ff       <= 1'b0;
         tracking_ff   <= 1'b0;
         countdown_ff  <= '0;
         motor_mask_ff <= '0;
         pump_mask_ff  <= '0;
         for (int i = 0; i < VAR_COUNT; i++) begin
            var_ff[i] <= var_init(VIDX_W'(i));
         end
      end else if (act_do) begin
         case (order_id)
            ORD_STOP:  stop_ff <= (cplm != 4'd0);
            ORD_PUMP:  pump_mask_ff <= arg_lo_ff;
            ORD_MOTOR_SEL: begin
               countdown_ff  <= cplm;
               motor_mask_ff <= arg_lo_ff;
            end
            ORD_MOTOR_ARG: begin
               if (motor_hit) begin
                  countdown_ff <= countdown_ff - 4'd1;
               end
            end
            ORD_VAR_WRITE: var_ff[cplm] <= {arg_hi_ff, arg_lo_ff};
            ORD_TRACK:     tracking_ff <= (cplm != 4'd0);
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // a held expiry exists only during a tick
   a_pend_in_tick: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (state_ff == ST_WALK || state_ff == ST_FLUSH))
      else $error("held expiry outside tick walk");

   // the result register is never overwritten while its beat waits
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result beat overwritten");

   // a tick while stopped returns straight to idle
   a_stopped_tick: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser && stop_ff) |=> (state_ff == ST_IDLE))
      else $error("stopped tick did work");

   // the action step counter only runs for the halt order
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (step_ff != 2'd0) |-> (state_ff == ST_ACT && order_id == ORD_HALT))
      else $error("action step counter out of place");

endmodule

`default_nettype wire

// ===== tb/command_responder_with_timers_unit_test.sv =====
// stream-level test of command_responder_with_timers_unit: drives orders and ticks,
// mirrors timers, flags and the variable store, and checks every response beat
// depends on cmdrsp_pkg and the rtl top level

import cmdrsp_pkg::*;

typedef struct packed {
   logic [HEAD_W-1:0] head;
   logic [WORD_W-1:0] payload;
   logic              last;
} resp_msg_t;

class responder_mirror;
   logic [TIMER_W-1:0] timers [TIMER_COUNT];
   logic [WORD_W-1:0]  vars [VAR_COUNT];
   logic [TIMER_W-1:0] durations [5];
   logic               stopped;
   logic               tracking;
   logic [3:0]         motor_left;
   logic [TIMER_W-1:0] motor_mask;
   logic [TIMER_W-1:0] pump_mask;
   resp_msg_t          expected_msgs [$];
   int                 failures;

   function new();
      failures = 0;
      foreach (timers[i]) timers[i] = '0;
      vars = '{32'h3F80_0000, 32'h4049_0E56, 32'h402E_147B, 32'h3FD8_1062,
               32'h3DCC_CCCD, 32'h0000_0000, 32'hC170_0000, 32'h3EE6_6666,
               32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
      durations[CSR_MOVE]        = 16'd160;
      durations[CSR_ROTATE]      = 16'd110;
      durations[CSR_MOTOR_VALUE] = 16'd150;
      durations[CSR_MOTOR_TIME]  = 16'd100;
      durations[CSR_MOTORS_DONE] = 16'd190;
      stopped    = 1'b0;
      tracking   = 1'b0;
      motor_left = '0;
      motor_mask = '0;
      pump_mask  = '0;
   endfunction

   function void set_register(logic [CSR_IDX_W-1:0] idx, logic [TIMER_W-1:0] value);
      case (idx)
         CSR_MOVE, CSR_ROTATE, CSR_MOTOR_VALUE, CSR_MOTOR_TIME, CSR_MOTORS_DONE:
            durations[idx] = value;
         default: ;
      endcase
   endfunction

   function void bump(logic [TIDX_W-1:0] slot);
      if (timers[slot] != '1) timers[slot] = timers[slot] + 1'b1;
   endfunction

   function void push(logic [HEAD_W-1:0] head, logic [WORD_W-1:0] payload);
      resp_msg_t m;
      m.head    = head;
      m.payload = payload;
      m.last    = 1'b0;
      expected_msgs.push_back(m);
   endfunction

   function void note_item(logic tick, logic [HEAD_W-1:0] head,
                           logic [ARG_W-1:0] arg_hi, logic [ARG_W-1:0] arg_lo);
      int         first;
      logic [3:0] id;
      logic [3:0] c;
      resp_msg_t  m;
      first = expected_msgs.size();
      id    = head[7:4];
      c     = head[3:0];
      if (tick) begin
         if (!stopped) begin
            for (int i = 0; i < TIMER_COUNT; i++) begin
               if (timers[i] != '0) begin
                  timers[i] = timers[i] - 1'b1;
                  if (timers[i] == '0) push({MSG_DONE, TIDX_W'(i)}, '0);
               end
            end
         end
      end else begin
         push({MSG_ACK, id}, '0);
         case (id)
            ORD_STOP:        stopped = (c != 0);
            ORD_MOVE:        timers[T_MOVE] = durations[CSR_MOVE];
            ORD_ROTATE:      timers[T_ROTATE] = durations[CSR_ROTATE];
            ORD_HALT: begin
               timers[T_ROTATE] = '0;
               timers[T_MOVE]   = '0;
               bump(T_HALT);
            end
            ORD_MOTOR_VALUE: timers[T_MOTOR_VALUE] = durations[CSR_MOTOR_VALUE];
            ORD_MOTOR_TIME:  timers[T_MOTOR_TIME] = durations[CSR_MOTOR_TIME];
            ORD_PUMP: begin
               pump_mask = arg_lo;
               bump(T_PUMP);
            end
            ORD_MOTOR_SEL: begin
               motor_left = c;
               motor_mask = arg_lo;
            end
            ORD_MOTOR_ARG: begin
               if (motor_left != 0 && motor_mask[c]) begin
                  motor_left = motor_left - 1'b1;
                  if (motor_left == 0) timers[T_MOTORS_DONE] = durations[CSR_MOTORS_DONE];
               end
            end
            ORD_VAR_WRITE: begin
               vars[c] = {arg_hi, arg_lo};
               bump(T_VAR_WRITE);
            end
            ORD_VAR_READ: begin
               push({MSG_VAR, c}, vars[c]);
               bump(T_VAR_READ);
            end
            ORD_TRACK: begin
               tracking = (c != 0);
               bump(T_TRACK);
            end
            default: ;
         endcase
      end
      if (expected_msgs.size() > first) begin
         m = expected_msgs.pop_back();
         m.last = 1'b1;
         expected_msgs.push_back(m);
      end
   endfunction

   function void flag(string what);
      failures++;
      if (failures <= 10) $display("mismatch: %s", what);
   endfunction

   function void check_msg(logic [HEAD_W-1:0] head, logic [WORD_W-1:0] payload, logic last);
      resp_msg_t want;
      if (expected_msgs.size() == 0) begin
         flag($sformatf("unexpected beat head %02h payload %08h last %0b",
                        head, payload, last));
         return;
      end
      want = expected_msgs.pop_front();
      if (head !== want.head || payload !== want.payload || last !== want.last)
         flag($sformatf("expected head %02h payload %08h last %0b, got %02h %08h %0b",
                        want.head, want.payload, want.last, head, payload, last));
   endfunction

   function void close_out();
      if (expected_msgs.size() != 0)
         flag($sformatf("%0d beats never arrived, next head %02h",
                        expected_msgs.size(), expected_msgs[0].head));
   endfunction
endclass

module command_responder_with_timers_unit_test;

   localparam int HALF_PERIOD    = 6;
   localparam int RESET_CYCLES   = 10;
   localparam int IDLE_PCT       = 27;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 40;      // margin for a tick walk to finish
   localparam int TIMEOUT_CYCLES = 400000;

   // register indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;
   // order ids with no action beyond the ack
   localparam logic [3:0] ORD_SPARE_LO = 4'd12;
   localparam logic [3:0] ORD_SPARE_HI = 4'd15;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // head_byte, arg_high, arg_low
   logic                  req_tuser = 1'b0; // command (1 = tick)
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // msg_head, msg_payload
   logic                  rsp_tlast;        // last_of_run
   logic                  csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [TIMER_W-1:0]    csr_wdata = '0;

   responder_mirror mirror = new();

   int   items_sent = 0;
   logic req_no_idle = 1'b0;    // sender offers back to back
   logic rsp_no_idle = 1'b0;    // receiver always ready
   logic rsp_hold_req = 1'b0;   // ask the receiver for one long hold-off

   command_responder_with_timers_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // run limit, well above the slowest legal run
   initial begin
      #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
      $display("command_responder_with_timers_unit test failed");
      $finish;
   end

   // receiver: take beats at the rising edge, decide ready at the falling edge
   initial begin : rsp_side
      int hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid === 1'b1 && rsp_tready)
            mirror.check_msg(rsp_tdata[HEAD_W-1:0], rsp_tdata[HEAD_W +: WORD_W], rsp_tlast);
         @(negedge clock);
         if (rsp_hold_req) begin
            // long hold-off so the result register fills and the block stalls its input
            rsp_hold_req = 1'b0;
            hold_left    = HOLD_CYCLES;
            rsp_tready  <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left--;
         end else begin
            rsp_tready <= rsp_no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // one request beat: optional random gap, then hold valid until taken
   task automatic send_item(logic tick, logic [HEAD_W-1:0] head,
                            logic [ARG_W-1:0] arg_hi, logic [ARG_W-1:0] arg_lo);
      if (!req_no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
         @(negedge clock) req_tvalid <= 1'b0;
         repeat ($urandom_range(0, 3)) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= tick;
      req_tdata  <= {arg_lo, arg_hi, head};
      do @(posedge clock); while (!req_tready);
      mirror.note_item(tick, head, arg_hi, arg_lo);
      items_sent++;
   endtask

   task automatic order(logic [3:0] id, logic [3:0] c,
                        logic [ARG_W-1:0] arg_hi, logic [ARG_W-1:0] arg_lo);
      send_item(1'b0, {id, c}, arg_hi, arg_lo);
   endtask

   // tick beats carry random data that the block must ignore
   task automatic tick();
      send_item(1'b1, HEAD_W'($urandom), ARG_W'($urandom), ARG_W'($urandom));
   endtask

   // sender stops and waits for every expected beat, then lets any tick walk finish
   task automatic drain();
      @(negedge clock) req_tvalid <= 1'b0;
      while (mirror.expected_msgs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [TIMER_W-1:0] value);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      mirror.set_register(idx, value);
   endtask

   task automatic write_durations(logic [TIMER_W-1:0] mv, logic [TIMER_W-1:0] rot,
                                  logic [TIMER_W-1:0] mval, logic [TIMER_W-1:0] mtime,
                                  logic [TIMER_W-1:0] mdone);
      write_reg(CSR_MOVE, mv);
      write_reg(CSR_ROTATE, rot);
      write_reg(CSR_MOTOR_VALUE, mval);
      write_reg(CSR_MOTOR_TIME, mtime);
      write_reg(CSR_MOTORS_DONE, mdone);
      @(negedge clock) csr_wen <= 1'b0;
   endtask

   // short durations so loaded timers expire within a few ticks
   task automatic write_short_durations();
      write_durations(TIMER_W'($urandom_range(1, 6)), TIMER_W'($urandom_range(1, 6)),
                      TIMER_W'($urandom_range(1, 6)), TIMER_W'($urandom_range(1, 6)),
                      TIMER_W'($urandom_range(1, 6)));
   endtask

   // mostly well-formed order sequences with random content, the rest noise
   task automatic run_random(int count);
      int                target;
      int                kind;
      int                picks;
      logic [3:0]        pos [3];
      logic [3:0]        slot;
      logic [TIMER_W-1:0] mask;
      logic [HEAD_W-1:0] head;
      target = items_sent + count;
      while (items_sent < target) begin
         kind = $urandom_range(0, 9);
         case (kind)
            0, 1, 2: repeat ($urandom_range(1, 4)) tick();
            3: begin
               // motor select, then one matching argument per count step
               picks = $urandom_range(1, 3);
               mask  = TIMER_W'($urandom);
               for (int k = 0; k < picks; k++) begin
                  pos[k] = 4'($urandom_range(0, 15));
                  mask[pos[k]] = 1'b1;
               end
               order(ORD_MOTOR_SEL, 4'(picks), ARG_W'($urandom), mask);
               for (int k = 0; k < picks; k++) begin
                  if ($urandom_range(0, 4) == 0)
                     order(ORD_MOTOR_ARG, 4'($urandom_range(0, 15)), ARG_W'($urandom),
                           ARG_W'($urandom));
                  order(ORD_MOTOR_ARG, pos[k], ARG_W'($urandom), ARG_W'($urandom));
               end
               repeat ($urandom_range(0, 3)) tick();
            end
            4: begin
               // store a word and read it back, sometimes another slot too
               slot = 4'($urandom_range(0, 15));
               order(ORD_VAR_WRITE, slot, ARG_W'($urandom), ARG_W'($urandom));
               order(ORD_VAR_READ, slot, ARG_W'($urandom), ARG_W'($urandom));
               if ($urandom_range(0, 1))
                  order(ORD_VAR_READ, 4'($urandom_range(0, 15)), ARG_W'($urandom),
                        ARG_W'($urandom));
            end
            5: begin
               // load or bump timers, then let time run
               case ($urandom_range(0, 6))
                  0: head = {ORD_MOVE, 4'($urandom_range(0, 15))};
                  1: head = {ORD_ROTATE, 4'($urandom_range(0, 15))};
                  2: head = {ORD_MOTOR_VALUE, 4'($urandom_range(0, 15))};
                  3: head = {ORD_MOTOR_TIME, 4'($urandom_range(0, 15))};
                  4: head = {ORD_HALT, 4'($urandom_range(0, 15))};
                  5: head = {ORD_PUMP, 4'($urandom_range(0, 15))};
                  default: head = {ORD_TRACK, 4'($urandom_range(0, 15))};
               endcase
               send_item(1'b0, head, ARG_W'($urandom), ARG_W'($urandom));
               repeat ($urandom_range(1, 6)) tick();
            end
            6: begin
               // stop, a tick that must do nothing, then run again
               order(ORD_STOP, 4'($urandom_range(1, 15)), ARG_W'($urandom), ARG_W'($urandom));
               tick();
               order(ORD_STOP, 4'h0, ARG_W'($urandom), ARG_W'($urandom));
            end
            default: begin
               // any head byte; keep a stray stop from freezing time too often
               head = HEAD_W'($urandom);
               if (head[7:4] == ORD_STOP && $urandom_range(0, 1)) head[3:0] = 4'h0;
               send_item(1'b0, head, ARG_W'($urandom), ARG_W'($urandom));
            end
         endcase
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed: every order, extremes of the fields, stop, saturating paths
      write_reg(CSR_SPARE_HI, 16'hFFFF);    // no register there, must be ignored
      write_reg(CSR_SPARE_LO, 16'h0001);
      write_durations(16'd1, 16'd2, 16'd3, 16'd0, 16'd2);
      order(ORD_STOP, 4'h0, 16'h0000, 16'h0000);
      order(ORD_MOVE, 4'hF, 16'hFFFF, 16'hFFFF);
      order(ORD_ROTATE, 4'h0, 16'h0000, 16'h0000);
      order(ORD_MOTOR_VALUE, 4'h3, 16'h1234, 16'h8001);
      order(ORD_MOTOR_TIME, 4'h0, 16'h0000, 16'h0000);   // zero duration, never expires
      tick();                                             // move timer expires
      order(ORD_HALT, 4'h0, 16'h0000, 16'h0000);
      tick();                                             // halt timer expires
      order(ORD_PUMP, 4'h0, 16'h0000, 16'hA5A5);
      order(ORD_MOTOR_SEL, 4'h2, 16'h0000, 16'h0005);
      order(ORD_MOTOR_ARG, 4'h1, 16'h0000, 16'h0000);     // bit not in mask, no count
      order(ORD_MOTOR_ARG, 4'h0, 16'h0000, 16'h0000);
      order(ORD_MOTOR_ARG, 4'h2, 16'h0000, 16'h0000);     // count ends, timer 7 loads
      order(ORD_VAR_WRITE, 4'hF, 16'hFFFF, 16'h0000);
      order(ORD_VAR_READ, 4'hF, 16'h0000, 16'h0000);
      order(ORD_VAR_READ, 4'h6, 16'hFFFF, 16'hFFFF);      // power-up word
      order(ORD_TRACK, 4'h1, 16'h0000, 16'h0000);
      order(ORD_SPARE_HI, 4'hF, 16'hFFFF, 16'hFFFF);
      order(ORD_SPARE_LO, 4'h0, 16'h0000, 16'h0000);
      order(ORD_STOP, 4'h5, 16'h0000, 16'h0000);
      tick();                                             // stopped, no beats
      order(ORD_STOP, 4'h0, 16'h0000, 16'h0000);
      tick();                                             // several timers end at once
      tick();
      tick();                                             // nothing left to expire
      drain();

      // zero durations: loads never expire
      write_durations(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      run_random(45);
      drain();

      // full-scale durations
      write_durations(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_random(40);
      drain();

      // receiver holds off while the sender keeps offering back to back
      write_short_durations();
      rsp_hold_req = 1'b1;
      req_no_idle  = 1'b1;
      run_random(40);
      req_no_idle  = 1'b0;
      run_random(30);
      drain();

      // a long stretch with no gaps on either side
      write_short_durations();
      req_no_idle = 1'b1;
      rsp_no_idle = 1'b1;
      run_random(50);
      req_no_idle = 1'b0;
      rsp_no_idle = 1'b0;
      drain();

      write_short_durations();
      run_random(60);
      drain();

      mirror.close_out();
      if (mirror.failures == 0)
         $display("command_responder_with_timers_unit test passed");
      else
         $display("command_responder_with_timers_unit test failed");
      $finish;
   end

endmodule
